[rtl/psst_pkg.sv]
`default_nettype none
package psst_pkg;

  localparam int NUM_SENSORS = 256;
  localparam int VALUE_BITS  = 16;
  localparam int COUNT_BITS  = 24;
  localparam int SUM_BITS    = VALUE_BITS + COUNT_BITS;
  localparam int ID_BITS     = 8;
  localparam int ADDR_BITS   = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic signed [VALUE_BITS-1:0] ANOMALY_CODE_RESET = VALUE_BITS'(-999);

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] min_v;
    logic signed [VALUE_BITS-1:0] max_v;
    logic signed [SUM_BITS-1:0]   sum_v;
    logic [COUNT_BITS-1:0]        count_v;
    logic [COUNT_BITS-1:0]        anom_v;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  localparam entry_t ENTRY_RESET = '{
    min_v:   VAL_MAX,
    max_v:   VAL_MIN,
    sum_v:   '0,
    count_v: '0,
    anom_v:  '0
  };

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage
`default_nettype wire

[rtl/psst_ram.sv]
`default_nettype none
module psst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                             clk,
  input  wire                             we,
  input  wire  [$clog2(DEPTH)-1:0]        waddr,
  input  wire  [WIDTH-1:0]                wdata,
  input  wire                             re,
  input  wire  [$clog2(DEPTH)-1:0]        raddr,
  output logic [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/psst_ctrl.sv]
`default_nettype none
module psst_ctrl
  import psst_pkg::*;
(
  input  wire   clk,
  input  wire   rst,
  input  wire   start,
  output logic  busy,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy       = 1'b1;
        cmd.exec   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/psst_datapath.sv]
`default_nettype none
module psst_datapath
  import psst_pkg::*;
(
  input  wire                              clk,
  input  wire                              rst,
  input  cmd_t                             cmd,
  input  wire                              cfg_write_en,
  input  wire  signed [VALUE_BITS-1:0]     cfg_write_data,
  input  wire                              opcode,
  input  wire         [ID_BITS-1:0]        sensor_id,
  input  wire  signed [VALUE_BITS-1:0]     sample_value,
  output logic                             result_strobe,
  output logic                             found,
  output logic signed [VALUE_BITS-1:0]     min_value,
  output logic signed [VALUE_BITS-1:0]     max_value,
  output logic signed [SUM_BITS-1:0]       sum_value,
  output logic        [COUNT_BITS-1:0]     sample_count,
  output logic        [COUNT_BITS-1:0]     anomalies
);

  logic signed [VALUE_BITS-1:0] anomaly_code;
  logic                         op_q;
  logic [ID_BITS-1:0]           id_q;
  logic signed [VALUE_BITS-1:0] val_q;
  logic [NUM_SENSORS-1:0]       valid;
  logic [ENTRY_BITS-1:0]        rd_data;
  logic [ADDR_BITS-1:0]         addr_q;
  logic                         in_range;
  logic                         present;
  logic                         wr_en;
  entry_t                       cur;
  entry_t                       upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      anomaly_code <= ANOMALY_CODE_RESET;
    end else if (cfg_write_en) begin
      anomaly_code <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= opcode;
      id_q  <= sensor_id;
      val_q <= sample_value;
    end
  end

  assign addr_q   = id_q[ADDR_BITS-1:0];
  assign in_range = 32'(id_q) < NUM_SENSORS;
  assign present  = in_range && valid[addr_q];
  assign wr_en    = cmd.exec && (op_q == OP_RECORD) && in_range;

  psst_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(NUM_SENSORS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr_q),
    .wdata (upd),
    .re    (cmd.load),
    .raddr (sensor_id[ADDR_BITS-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[addr_q] <= 1'b1;
    end
  end

  always_comb begin
    cur = present ? entry_t'(rd_data) : ENTRY_RESET;
    upd = cur;
    if (val_q == anomaly_code) begin
      if (cur.anom_v != COUNT_MAX) begin
        upd.anom_v = cur.anom_v + COUNT_BITS'(1);
      end
    end else begin
      if (val_q < cur.min_v) begin
        upd.min_v = val_q;
      end
      if (val_q > cur.max_v) begin
        upd.max_v = val_q;
      end
      if (cur.count_v != COUNT_MAX) begin
        upd.sum_v   = cur.sum_v + SUM_BITS'(val_q);
        upd.count_v = cur.count_v + COUNT_BITS'(1);
      end
    end
  end

  assign result_strobe = cmd.exec && (op_q == OP_QUERY);
  assign found         = present;
  assign min_value     = cur.min_v;
  assign max_value     = cur.max_v;
  assign sum_value     = cur.sum_v;
  assign sample_count  = cur.count_v;
  assign anomalies     = cur.anom_v;

endmodule
`default_nettype wire

[rtl/per_sensor_statistics_table.sv]
// Per-sensor statistics table: min, max, sum, sample count and anomaly count
// kept for each sensor id in a single-port-read, single-port-write RAM.
// Input: raise start with opcode, sensor_id and sample_value; the transfer
// happens at a rising edge with start high and busy low. Opcode 0 records a
// sample, opcode 1 queries an entry.
// Output: a query produces one result on the result ports, marked by
// result_strobe for exactly one cycle, the cycle right after the accepting
// edge; the result is taken at the next edge.
// A record produces nothing. The receiver cannot stall; results are taken
// as they appear.
// Items do not overlap: the RAM read in the accept cycle is followed by the
// update-and-write cycle, during which busy is high and no start is taken.
// Configuration: cfg_write_en/cfg_write_data write the anomaly code at once;
// write only while no item is in flight.
// Reset (rst, synchronous): clears all per-entry valid flags, so every entry
// reads as empty; the anomaly code returns to -999.
`default_nettype none
module per_sensor_statistics_table
  import psst_pkg::*;
(
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  output logic                             busy,
  input  wire                              cfg_write_en,
  input  wire  signed [VALUE_BITS-1:0]     cfg_write_data,
  input  wire                              opcode,
  input  wire         [ID_BITS-1:0]        sensor_id,
  input  wire  signed [VALUE_BITS-1:0]     sample_value,
  output logic                             result_strobe,
  output logic                             found,
  output logic signed [VALUE_BITS-1:0]     min_value,
  output logic signed [VALUE_BITS-1:0]     max_value,
  output logic signed [SUM_BITS-1:0]       sum_value,
  output logic        [COUNT_BITS-1:0]     sample_count,
  output logic        [COUNT_BITS-1:0]     anomalies
);

  cmd_t cmd;

  psst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  psst_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .opcode         (opcode),
    .sensor_id      (sensor_id),
    .sample_value   (sample_value),
    .result_strobe  (result_strobe),
    .found          (found),
    .min_value      (min_value),
    .max_value      (max_value),
    .sum_value      (sum_value),
    .sample_count   (sample_count),
    .anomalies      (anomalies)
  );

endmodule
`default_nettype wire
